// ----- rtl/dabcc_pkg.sv -----
// ----------------------------------------------------------------------------
// dabcc_pkg
// Shared widths, constants and controller/datapath command types for the
// dual-axis balance cascade controller.
// ----------------------------------------------------------------------------
package dabcc_pkg;

  localparam int DRIVE_LIMIT = 7200;
  localparam int SUM_LIMIT   = 3000;

  localparam int NUM_REGS    = 8;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 16;

  localparam int ANGLE_W     = 17;
  localparam int RAW_W       = 16;
  localparam int DRIVE_W     = 14;

  localparam int IN_FIELDS_W = 2 * ANGLE_W + 4 * RAW_W;
  localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = 2 * DRIVE_W;
  localparam int OUT_TDATA_W = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam int NEUTRAL_FB  = 845;
  localparam int TILT_LIMIT  = 7680;
  localparam int W_NEW       = 77;
  localparam int W_OLD       = 179;

  localparam logic [CFG_ADDR_W-1:0] REG_FB_ANGLE   = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_SIDE_ANGLE = 3'd4;

  localparam logic [1:0] GAIN_ANGLE = 2'd0;
  localparam logic [1:0] GAIN_RATE  = 2'd1;
  localparam logic [1:0] GAIN_SPEED = 2'd2;
  localparam logic [1:0] GAIN_SUM   = 2'd3;

  localparam logic AXIS_SIDE = 1'b0;
  localparam logic AXIS_FB   = 1'b1;

  localparam logic signed [CFG_DATA_W-1:0] GAIN_RESET [NUM_REGS] = '{
    -16'sd810, -16'sd3456, -16'sd1000, 16'sd0,
    -16'sd1850, -16'sd192, 16'sd0, 16'sd0
  };

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_NEW,
    MUL_OLD,
    MUL_ANGLE,
    MUL_RATE,
    MUL_SPEED,
    MUL_SUM
  } mul_op_e;

  typedef enum logic [1:0] {
    FACC_HOLD,
    FACC_LOAD,
    FACC_ADD
  } facc_op_e;

  typedef enum logic [1:0] {
    TERM_HOLD,
    TERM_LOAD,
    TERM_ADD
  } term_op_e;

  typedef struct packed {
    logic     load;
    logic     axis;
    mul_op_e  mul_op;
    facc_op_e facc_op;
    term_op_e term_op;
    logic     filt_wr;
    logic     sum_wr;
    logic     side_wr;
    logic     out_wr;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } stat_t;

endpackage

// ----- rtl/dabcc_ctrl.sv -----
// ----------------------------------------------------------------------------
// dabcc_ctrl
// Sequencer: steps the shared multiplier through both axes of one tick.
// ----------------------------------------------------------------------------
module dabcc_ctrl import dabcc_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_F0,
    ST_F1,
    ST_F2,
    ST_F3,
    ST_F4,
    ST_F5,
    ST_F6,
    ST_FIN
  } state_e;

  state_e state_q;
  logic   axis_q;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    cmd_o         = '0;
    cmd_o.axis    = axis_q;
    cmd_o.mul_op  = MUL_NONE;
    cmd_o.facc_op = FACC_HOLD;
    cmd_o.term_op = TERM_HOLD;
    case (state_q)
      ST_IDLE: begin
        cmd_o.load = in_valid_i;
      end
      ST_F0: begin
        cmd_o.mul_op  = MUL_NEW;
        cmd_o.side_wr = (axis_q == AXIS_FB);
      end
      ST_F1: begin
        cmd_o.mul_op  = MUL_OLD;
        cmd_o.facc_op = FACC_LOAD;
      end
      ST_F2: begin
        cmd_o.mul_op  = MUL_ANGLE;
        cmd_o.facc_op = FACC_ADD;
      end
      ST_F3: begin
        cmd_o.mul_op  = MUL_RATE;
        cmd_o.filt_wr = 1'b1;
        cmd_o.term_op = TERM_LOAD;
      end
      ST_F4: begin
        cmd_o.mul_op  = MUL_SPEED;
        cmd_o.sum_wr  = 1'b1;
        cmd_o.term_op = TERM_ADD;
      end
      ST_F5: begin
        cmd_o.mul_op  = MUL_SUM;
        cmd_o.term_op = TERM_ADD;
      end
      ST_F6: begin
        cmd_o.term_op = TERM_ADD;
      end
      ST_FIN: begin
        cmd_o.out_wr = stat_i.out_free;
      end
      default: begin
        cmd_o.load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      axis_q  <= AXIS_SIDE;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q <= ST_F0;
            axis_q  <= AXIS_SIDE;
          end
        end
        ST_F0: state_q <= ST_F1;
        ST_F1: state_q <= ST_F2;
        ST_F2: state_q <= ST_F3;
        ST_F3: state_q <= ST_F4;
        ST_F4: state_q <= ST_F5;
        ST_F5: state_q <= ST_F6;
        ST_F6: begin
          if (axis_q == AXIS_SIDE) begin
            axis_q  <= AXIS_FB;
            state_q <= ST_F0;
          end else begin
            state_q <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (stat_i.out_free) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/dabcc_dp.sv -----
// ----------------------------------------------------------------------------
// dabcc_dp
// Datapath: gain registers, one shared 16x25 multiplier, filter, integral
// and term accumulators, drive clamps and the result register.
// ----------------------------------------------------------------------------
module dabcc_dp import dabcc_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  input  logic [IN_TDATA_W-1:0]  in_data_i,
  input  cmd_t                   cmd_i,
  output stat_t                  stat_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [OUT_TDATA_W-1:0] out_data_o,
  output logic                   out_tilted_o
);

  localparam int A_W    = 16;
  localparam int B_W    = 25;
  localparam int PROD_W = A_W + B_W;
  localparam int SHR_W  = PROD_W - 8;
  localparam int FACC_W = 34;
  localparam int FILT_W = 24;
  localparam int SUM_W  = 21;
  localparam int SNEW_W = 25;
  localparam int TERM_W = 36;
  localparam int DIFF_W = ANGLE_W + 1;

  localparam logic signed [SNEW_W-1:0] SUM_MAX = SNEW_W'(SUM_LIMIT * 256);
  localparam logic signed [SNEW_W-1:0] SUM_MIN = -SNEW_W'(SUM_LIMIT * 256);
  localparam logic signed [TERM_W-1:0] DRV_MAX = TERM_W'(DRIVE_LIMIT);
  localparam logic signed [TERM_W-1:0] DRV_MIN = -TERM_W'(DRIVE_LIMIT);
  localparam logic signed [ANGLE_W-1:0] TILT_HI = ANGLE_W'(TILT_LIMIT);
  localparam logic signed [ANGLE_W-1:0] TILT_LO = -ANGLE_W'(TILT_LIMIT);

  function automatic logic signed [SHR_W-1:0] trunc8(input logic signed [PROD_W-1:0] v);
    logic signed [SHR_W-1:0] q;
    q = v[PROD_W-1:8];
    if (v[PROD_W-1] && (v[7:0] != 8'd0)) q = q + SHR_W'(1);
    return q;
  endfunction

  function automatic logic signed [TERM_W-1:0] clamp_drv(input logic signed [TERM_W-1:0] v);
    logic signed [TERM_W-1:0] r;
    r = v;
    if (v > DRV_MAX) r = DRV_MAX;
    if (v < DRV_MIN) r = DRV_MIN;
    return r;
  endfunction

  logic signed [CFG_DATA_W-1:0] gain_q [NUM_REGS];

  logic signed [ANGLE_W-1:0] pitch_q, roll_q;
  logic signed [RAW_W-1:0]   rate_x_q, rate_y_q, lsp_q, usp_q;
  logic                      tilted_q;

  logic signed [FILT_W-1:0] filt_q [2];
  logic signed [SUM_W-1:0]  sum_q [2];

  logic signed [PROD_W-1:0] p_q;
  logic signed [FACC_W-1:0] facc_q;
  logic signed [TERM_W-1:0] term_q, side_q;

  logic signed [DRIVE_W-1:0] up_q, lo_q;
  logic                      valid_q, tilt_out_q;

  logic signed [ANGLE_W-1:0] in_pitch, in_roll;
  logic                      in_tilted;
  logic [CFG_ADDR_W-1:0]     gidx;
  logic signed [A_W-1:0]     op_a;
  logic signed [B_W-1:0]     op_b;
  logic signed [ANGLE_W-1:0] angle_sel;
  logic signed [RAW_W-1:0]   rate_sel, speed_sel;
  logic signed [DIFF_W-1:0]  angle_diff;
  logic signed [FILT_W-1:0]  filt_sel;
  logic signed [SUM_W-1:0]   sum_sel;
  logic signed [SHR_W-1:0]   p_shr, facc_shr;
  logic signed [SNEW_W-1:0]  sum_new;
  logic signed [TERM_W-1:0]  up_wide, lo_wide;

  assign in_pitch  = in_data_i[ANGLE_W-1:0];
  assign in_roll   = in_data_i[2*ANGLE_W-1:ANGLE_W];
  assign in_tilted = (in_pitch >= TILT_HI) || (in_pitch <= TILT_LO) ||
                     (in_roll >= TILT_HI) || (in_roll <= TILT_LO);

  always_comb begin
    angle_sel  = (cmd_i.axis == AXIS_SIDE) ? pitch_q : roll_q;
    rate_sel   = (cmd_i.axis == AXIS_SIDE) ? rate_x_q : rate_y_q;
    speed_sel  = (cmd_i.axis == AXIS_SIDE) ? usp_q : lsp_q;
    filt_sel   = filt_q[cmd_i.axis];
    sum_sel    = sum_q[cmd_i.axis];
    angle_diff = (cmd_i.axis == AXIS_SIDE) ? DIFF_W'(angle_sel)
                                           : DIFF_W'(angle_sel) - DIFF_W'(NEUTRAL_FB);
    gidx = (cmd_i.axis == AXIS_SIDE) ? REG_SIDE_ANGLE : REG_FB_ANGLE;
    op_a = '0;
    op_b = '0;
    case (cmd_i.mul_op)
      MUL_NEW: begin
        op_a = A_W'(W_NEW);
        op_b = B_W'(speed_sel);
      end
      MUL_OLD: begin
        op_a = A_W'(W_OLD);
        op_b = B_W'(filt_sel);
      end
      MUL_ANGLE: begin
        op_a = gain_q[gidx | CFG_ADDR_W'(GAIN_ANGLE)];
        op_b = B_W'(angle_diff);
      end
      MUL_RATE: begin
        op_a = gain_q[gidx | CFG_ADDR_W'(GAIN_RATE)];
        op_b = B_W'(rate_sel);
      end
      MUL_SPEED: begin
        op_a = gain_q[gidx | CFG_ADDR_W'(GAIN_SPEED)];
        op_b = B_W'(filt_sel);
      end
      MUL_SUM: begin
        op_a = gain_q[gidx | CFG_ADDR_W'(GAIN_SUM)];
        op_b = B_W'(sum_sel);
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  always_comb begin
    p_shr    = trunc8(p_q);
    facc_shr = trunc8(PROD_W'(facc_q));
    sum_new  = SNEW_W'(sum_sel) + SNEW_W'(filt_sel);
    if (sum_new > SUM_MAX) sum_new = SUM_MAX;
    if (sum_new < SUM_MIN) sum_new = SUM_MIN;
    up_wide  = clamp_drv(-side_q);
    lo_wide  = clamp_drv(term_q);
  end

  assign stat_o.out_free = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_REGS; i++) gain_q[i] <= GAIN_RESET[i];
    end else if (cfg_we_i) begin
      gain_q[cfg_addr_i] <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      pitch_q  <= in_pitch;
      roll_q   <= in_roll;
      rate_x_q <= in_data_i[2*ANGLE_W+RAW_W-1:2*ANGLE_W];
      rate_y_q <= in_data_i[2*ANGLE_W+2*RAW_W-1:2*ANGLE_W+RAW_W];
      lsp_q    <= in_data_i[2*ANGLE_W+3*RAW_W-1:2*ANGLE_W+2*RAW_W];
      usp_q    <= in_data_i[2*ANGLE_W+4*RAW_W-1:2*ANGLE_W+3*RAW_W];
      tilted_q <= in_tilted;
    end
    p_q <= op_a * op_b;
    case (cmd_i.facc_op)
      FACC_LOAD: facc_q <= {p_q[FACC_W-9:0], 8'd0};
      FACC_ADD:  facc_q <= facc_q + p_q[FACC_W-1:0];
      default:   facc_q <= facc_q;
    endcase
    case (cmd_i.term_op)
      TERM_LOAD: term_q <= TERM_W'(p_shr);
      TERM_ADD:  term_q <= term_q + TERM_W'(p_shr);
      default:   term_q <= term_q;
    endcase
    if (cmd_i.side_wr) side_q <= term_q;
    if (cmd_i.out_wr) begin
      up_q       <= tilted_q ? '0 : up_wide[DRIVE_W-1:0];
      lo_q       <= tilted_q ? '0 : lo_wide[DRIVE_W-1:0];
      tilt_out_q <= tilted_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filt_q[0] <= '0;
      filt_q[1] <= '0;
      sum_q[0]  <= '0;
      sum_q[1]  <= '0;
      valid_q   <= 1'b0;
    end else begin
      if (cmd_i.filt_wr) filt_q[cmd_i.axis] <= facc_shr[FILT_W-1:0];
      if (cmd_i.sum_wr) sum_q[cmd_i.axis] <= sum_new[SUM_W-1:0];
      if (cmd_i.out_wr && tilted_q) begin
        sum_q[0] <= '0;
        sum_q[1] <= '0;
      end
      if (cmd_i.out_wr) begin
        valid_q <= 1'b1;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o  = valid_q;
  assign out_data_o   = {{(OUT_TDATA_W-OUT_FIELDS_W){1'b0}}, lo_q, up_q};
  assign out_tilted_o = tilt_out_q;

endmodule

// ----- rtl/dual_axis_balance_cascade_controller_core.sv -----
// ----------------------------------------------------------------------------
// dual_axis_balance_cascade_controller_core
// Per-tick PD angle plus PI speed cascade for two axes of a balancing robot.
// ----------------------------------------------------------------------------
// One beat on the slave stream carries one control tick: angles, gyro rates
// and encoder speeds. One beat on the master stream returns the two motor
// drives, with the tilt flag in tuser. Gains are written through the cfg
// port; the user must write them only while the block is idle (the block
// does not enforce it). Index i selects gain register i. A tick runs two
// axes of seven sequencer steps each, a write-back step and the idle step
// that takes the next beat, so no beat is taken before the last tick is
// through; its twelve products pass through the single shared 16x25 multiplier.
// The input is taken again as soon as a tick's drives are in the output
// register; if the receiver stalls, a finished tick waits in the output
// register and the next tick is computed, then held in its write-back step
// until the earlier beat is taken.
// Reset loads the default gains and clears the speed filters and speed sums.
// ----------------------------------------------------------------------------
module dual_axis_balance_cascade_controller_core import dabcc_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // pitch_angle, roll_angle, rate_x, rate_y, lower_motor_speed, upper_motor_speed
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // upper_drive, lower_drive
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // tilted
  output logic                   m_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  input  logic                   cfg_we_i,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i
);

  cmd_t  cmd;
  stat_t stat;

  dabcc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  dabcc_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_data_i   (cfg_data_i),
    .in_data_i    (s_axis_tdata),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_data_o   (m_axis_tdata),
    .out_tilted_o (m_axis_tuser)
  );

endmodule
